// ===== sv/pafu_pkg.sv =====
`default_nettype none

package pafu_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 16;
    localparam int OPCODE_W            = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_CMP = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EXEC,
        ST_MUL,
        ST_ALIGN,
        ST_DIVIDE,
        ST_UPDATE,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== sv/prime_field_arithmetic_unit_core.sv =====
// add, subtract, negate, compare: both operands are first reduced mod p bit-serially (REDUCE), then EXEC
// and FINISH; multiply adds a bit-serial modular product (MUL); divide runs extended euclid on p and b,
//   each step ALIGN, DIVIDE and UPDATE, then the product of a with the coefficient t1 in MUL.
// one item at a time, set by the bit-serial reduce loop and the shared modular mac unit
// the finished result sits in an output register, so the next item is taken while it waits
// rst_n is asynchronous active low: clears the fsm, the output valid and sets modulus to 2
`default_nettype none

module prime_field_arithmetic_unit_core #(
    parameter int VALUE_WIDTH = pafu_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // configuration: modulus
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [VALUE_WIDTH-1:0]                   cfg_data,
    // tdata: operand_a, operand_b
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    input  wire logic [((2*VALUE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // tuser: opcode
    input  wire logic [pafu_pkg::OPCODE_W-1:0]            s_axis_tuser,
    // tdata: result_value, is_equal, is_less, is_greater, divide_by_zero
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    output logic [((VALUE_WIDTH+4+7)/8)*8-1:0]            m_axis_tdata
);
    import pafu_pkg::*;

    localparam int W     = VALUE_WIDTH;
    localparam int OUT_W = ((VALUE_WIDTH + 4 + 7) / 8) * 8;
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    // (2*acc + dig*x) mod p, with acc and x already below p
    function automatic logic [W-1:0] mod_mac(
        input logic [W-1:0] acc,
        input logic         dig,
        input logic [W-1:0] x,
        input logic [W-1:0] p
    );
        logic [W:0] dbl;
        logic [W:0] sum;
        dbl = {acc, 1'b0};
        if (dbl >= {1'b0, p})
        begin
            dbl = dbl - {1'b0, p};
        end
        sum = {1'b0, dbl[W-1:0]} + (dig ? {1'b0, x} : {(W+1){1'b0}});
        if (sum >= {1'b0, p})
        begin
            sum = sum - {1'b0, p};
        end
        return sum[W-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [W-1:0]     p_reg;
    opcode_t          op_reg;
    logic [W-1:0]     a_sh_reg, b_sh_reg;
    logic [W-1:0]     ra_reg, rb_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     r0_reg, r1_reg, d_reg;
    logic [W-1:0]     t0_reg, t1_reg;
    logic [W-1:0]     acc_reg;
    logic [W-1:0]     mul_x_reg, mul_sh_reg;
    logic [W-1:0]     res_reg;
    logic             eq_reg, lt_reg, gt_reg, dz_reg;
    logic             m_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic             in_xfer;
    logic             load_out;
    logic [W:0]       red_a_t, red_b_t;
    logic [W-1:0]     red_a, red_b;
    logic             align_go;
    logic             q_bit;
    logic             mac_dig;
    logic [W-1:0]     mac_x;
    logic [W-1:0]     mac_out;
    logic [W-1:0]     t_new;
    logic [W:0]       add_s;
    logic [W-1:0]     add_r, sub_r, neg_r;

    // ---------------- datapath helpers ----------------
    always_comb
    begin
        red_a_t = {ra_reg, a_sh_reg[W-1]};
        red_b_t = {rb_reg, b_sh_reg[W-1]};
        red_a   = (red_a_t >= {1'b0, p_reg}) ? W'(red_a_t - {1'b0, p_reg}) : red_a_t[W-1:0];
        red_b   = (red_b_t >= {1'b0, p_reg}) ? W'(red_b_t - {1'b0, p_reg}) : red_b_t[W-1:0];

        align_go = ({d_reg, 1'b0} <= {1'b0, r0_reg});
        q_bit    = (d_reg <= r0_reg);

        mac_dig = (state_reg == ST_MUL) ? mul_sh_reg[W-1] : q_bit;
        mac_x   = (state_reg == ST_MUL) ? mul_x_reg : t1_reg;
        mac_out = mod_mac(acc_reg, mac_dig, mac_x, p_reg);

        // t0 - q*t1, all mod p
        t_new = (t0_reg >= acc_reg) ? (t0_reg - acc_reg) : (t0_reg - acc_reg + p_reg);

        add_s = {1'b0, ra_reg} + {1'b0, rb_reg};
        add_r = (add_s >= {1'b0, p_reg}) ? W'(add_s - {1'b0, p_reg}) : add_s[W-1:0];
        sub_r = (ra_reg >= rb_reg) ? (ra_reg - rb_reg) : (ra_reg - rb_reg + p_reg);
        neg_r = (ra_reg == '0) ? '0 : (p_reg - ra_reg);
    end

    // ---------------- fsm next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (op_reg == OP_MUL)
                begin
                    state_next = ST_MUL;
                end
                else if (op_reg == OP_DIV && rb_reg != '0)
                begin
                    state_next = ST_ALIGN;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_ALIGN:
            begin
                if (!align_go)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // r0 holds the new remainder here
                state_next = (r0_reg == '0) ? ST_MUL : ST_ALIGN;
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- fsm outputs ----------------
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        load_out      = (state_reg == ST_FINISH) && (!m_valid_reg || m_axis_tready);
    end

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            p_reg       <= W'(2);
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                p_reg <= (cfg_data < W'(2)) ? W'(2) : cfg_data;
            end
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:   cnt_reg <= CNT_W'(W - 1);
                ST_REDUCE,
                ST_MUL,
                ST_DIVIDE: cnt_reg <= cnt_reg - CNT_W'(1);
                ST_EXEC:   cnt_reg <= (op_reg == OP_MUL) ? CNT_W'(W - 1) : '0;
                ST_ALIGN:  cnt_reg <= align_go ? (cnt_reg + CNT_W'(1)) : cnt_reg;
                ST_UPDATE: cnt_reg <= (r0_reg == '0) ? CNT_W'(W - 1) : '0;
                default:   cnt_reg <= cnt_reg;
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_reg   <= opcode_t'(s_axis_tuser);
                    a_sh_reg <= s_axis_tdata[W-1:0];
                    b_sh_reg <= s_axis_tdata[2*W-1:W];
                    ra_reg   <= '0;
                    rb_reg   <= '0;
                end
            end
            ST_REDUCE:
            begin
                ra_reg   <= red_a;
                rb_reg   <= red_b;
                a_sh_reg <= {a_sh_reg[W-2:0], 1'b0};
                b_sh_reg <= {b_sh_reg[W-2:0], 1'b0};
            end
            ST_EXEC:
            begin
                acc_reg <= '0;
                res_reg <= (op_reg == OP_ADD) ? add_r :
                           (op_reg == OP_SUB) ? sub_r :
                           (op_reg == OP_NEG) ? neg_r : '0;
                eq_reg  <= (op_reg == OP_CMP) && (ra_reg == rb_reg);
                lt_reg  <= (op_reg == OP_CMP) && (ra_reg < rb_reg);
                gt_reg  <= (op_reg == OP_CMP) && (ra_reg > rb_reg);
                dz_reg  <= (op_reg == OP_DIV) && (rb_reg == '0);
                unique case (op_reg)
                    OP_MUL:
                    begin
                        mul_x_reg  <= ra_reg;
                        mul_sh_reg <= rb_reg;
                    end
                    OP_DIV:
                    begin
                        r0_reg <= p_reg;
                        r1_reg <= rb_reg;
                        d_reg  <= rb_reg;
                        t0_reg <= '0;
                        t1_reg <= W'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_ALIGN:
            begin
                if (align_go)
                begin
                    d_reg <= {d_reg[W-2:0], 1'b0};
                end
            end
            ST_DIVIDE:
            begin
                // one quotient bit per cycle, q*t1 accumulated mod p
                acc_reg <= mac_out;
                if (q_bit)
                begin
                    r0_reg <= r0_reg - d_reg;
                end
                d_reg <= {1'b0, d_reg[W-1:1]};
            end
            ST_UPDATE:
            begin
                r0_reg  <= r1_reg;
                r1_reg  <= r0_reg;
                d_reg   <= r0_reg;
                t0_reg  <= t1_reg;
                t1_reg  <= t_new;
                acc_reg <= '0;
                if (r0_reg == '0)
                begin
                    // euclid done: coefficient is t1, product with a comes next
                    mul_x_reg  <= ra_reg;
                    mul_sh_reg <= t1_reg;
                end
            end
            ST_MUL:
            begin
                acc_reg    <= mac_out;
                mul_sh_reg <= {mul_sh_reg[W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    res_reg <= mac_out;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    out_data_reg <= OUT_W'({dz_reg, gt_reg, lt_reg, eq_reg, res_reg});
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/pafu_checker.sv =====
`default_nettype none

module pafu_checker #(
    parameter int VALUE_WIDTH = pafu_pkg::VALUE_WIDTH_DEFAULT
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [((VALUE_WIDTH+4+7)/8)*8-1:0]   m_axis_tdata
);
    localparam int W = VALUE_WIDTH;

    // a waiting result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // busy right after an input transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // at most one comparison flag
    a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[W+2:W]))
        else $error("more than one comparison flag");

    // divide by zero gives a zero value and no comparison flag
    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[W+3] |->
            m_axis_tdata[W-1:0] == '0 && m_axis_tdata[W+2:W] == '0)
        else $error("divide by zero result not clean");

    // compare gives a zero value
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[W+2:W] != '0 |-> m_axis_tdata[W-1:0] == '0)
        else $error("compare result value not zero");

endmodule

bind prime_field_arithmetic_unit_core pafu_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_pafu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
